// ===== rtl/v34m_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// v34m_pkg
// shared types and constants of the vector math unit
// ----------------------------------------------------------------------------
package v34m_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int NUM_LANES      = 4;
   localparam int NUM_PRODS      = 6;
   localparam int QUEUE_DEPTH    = 2;

   typedef enum logic [1:0] {
      OP_DOT   = 2'd0,
      OP_CROSS = 2'd1,
      OP_MAG   = 2'd2,
      OP_NORM  = 2'd3
   } op_type;

   typedef struct packed {
      op_type op;
      logic   four;
   } ctl_type;

   localparam int CTL_BITS = $bits(ctl_type);

   // cross product operand lanes: x = a_y*b_z - a_z*b_y and so on
   localparam int CROSS_A [NUM_PRODS] = '{1, 2, 2, 0, 0, 1};
   localparam int CROSS_B [NUM_PRODS] = '{2, 1, 0, 2, 1, 0};

endpackage
`default_nettype wire

// ===== rtl/v34m_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// v34m_front
// takes command words, masks unused w lanes, picks operands and multiplies
// ----------------------------------------------------------------------------
module v34m_front import v34m_pkg::*; #(
   parameter int W = DATA_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                take,
   input  logic                                stall,
   input  ctl_type                             ctl_in,
   input  logic [NUM_LANES-1:0][W-1:0]         a_in,
   input  logic [NUM_LANES-1:0][W-1:0]         b_in,
   output logic                                push,
   output ctl_type                             ctl_out,
   output logic [NUM_LANES-1:0][W-1:0]         a_out,
   output logic [NUM_PRODS-1:0][2*W-1:0]       prod_out
);

   logic                        a_vld_ff;
   ctl_type                     a_ctl_ff;
   logic [NUM_LANES-1:0][W-1:0] a_a_ff;
   logic [NUM_LANES-1:0][W-1:0] a_b_ff;
   logic [NUM_LANES-1:0][W-1:0] a_a_in;
   logic [NUM_LANES-1:0][W-1:0] a_b_in;

   logic                          b_vld_ff;
   ctl_type                       b_ctl_ff;
   logic [NUM_LANES-1:0][W-1:0]   b_a_ff;
   logic [NUM_PRODS-1:0][2*W-1:0] b_prod_ff;
   logic [NUM_PRODS-1:0][2*W-1:0] b_prod_in;
   logic [NUM_PRODS-1:0][W-1:0]   opx;
   logic [NUM_PRODS-1:0][W-1:0]   opy;

   // three component mode zeroes w so it drops out of dot and square sums
   always_comb begin
      a_a_in = a_in;
      a_b_in = b_in;
      if (!ctl_in.four) begin
         a_a_in[NUM_LANES-1] = '0;
         a_b_in[NUM_LANES-1] = '0;
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_PRODS; k++) begin
         opx[k] = a_a_ff[CROSS_A[k]];
         opy[k] = a_b_ff[CROSS_B[k]];
         if (k < NUM_LANES) begin
            unique case (a_ctl_ff.op)
               OP_DOT: begin
                  opx[k] = a_a_ff[k];
                  opy[k] = a_b_ff[k];
               end
               OP_MAG, OP_NORM: begin
                  opx[k] = a_a_ff[k];
                  opy[k] = a_a_ff[k];
               end
               default: ;
            endcase
         end
         b_prod_in[k] = (2*W)'($signed(opx[k]) * $signed(opy[k]));
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         a_vld_ff  <= take;
         a_ctl_ff  <= ctl_in;
         a_a_ff    <= a_a_in;
         a_b_ff    <= a_b_in;
         b_vld_ff  <= a_vld_ff;
         b_ctl_ff  <= a_ctl_ff;
         b_a_ff    <= a_a_ff;
         b_prod_ff <= b_prod_in;
      end
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end
   end

   assign push     = b_vld_ff & ~stall;
   assign ctl_out  = b_ctl_ff;
   assign a_out    = b_a_ff;
   assign prod_out = b_prod_ff;

endmodule
`default_nettype wire

// ===== rtl/v34m_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// v34m_queue
// short word queue between front and back
// ----------------------------------------------------------------------------
module v34m_queue import v34m_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic             full,
   output logic             rd_vld,
   output logic [WIDTH-1:0] rdata
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PW-1:0]    wptr_ff;
   logic [PW-1:0]    rptr_ff;
   logic [CW-1:0]    count_ff;
   logic             do_pop;

   function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   assign rd_vld = (count_ff != '0);
   assign full   = (count_ff == CW'(DEPTH));
   assign do_pop = pop & rd_vld;
   assign rdata  = mem[rptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wptr_ff <= nxt(wptr_ff);
         end
         if (do_pop) begin
            rptr_ff <= nxt(rptr_ff);
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (!push && do_pop) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

endmodule
`default_nettype wire

// ===== rtl/v34m_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// v34m_back
// sums, rounding, pipelined square root and divide, result formatting
// ----------------------------------------------------------------------------
module v34m_back import v34m_pkg::*; #(
   parameter int W = DATA_WIDTH_DEF,
   parameter int F = FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_vld,
   input  ctl_type                       in_ctl,
   input  logic [NUM_LANES-1:0][W-1:0]   in_a,
   input  logic [NUM_PRODS-1:0][2*W-1:0] in_prod,
   output logic                          out_vld,
   output logic [NUM_LANES-1:0][W-1:0]   out_res,
   output logic [W-1:0]                  out_scalar,
   output logic                          out_zero,
   output logic                          out_ovf
);

   localparam int PW = 2 * W;
   localparam int AW = 2 * W + 2;
   localparam int RW = W + 1;
   localparam int SP = 2 * RW;
   localparam int QW = F + 2;        // normalised magnitude stays below 2^(F+1)
   localparam int NW = W + F + 2;
   localparam int CW = W + QW;

   localparam logic [W-1:0]  MAXV = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]  MINV = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0]  ONE  = {{(W-1){1'b0}}, 1'b1} << F;
   localparam logic [CW-1:0] LIM  = {{(CW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
   localparam logic [AW-1:0] HALF = {{(AW-1){1'b0}}, 1'b1} << (F - 1);

   typedef struct packed {
      logic                        vld;
      ctl_type                     ctl;
      logic [NUM_LANES-1:0][W-1:0] a;
      logic [W-1:0]                dot;
      logic [2:0][W-1:0]           cr;
      logic                        rovf;
   } pay_type;

   typedef struct packed {
      pay_type              p;
      logic [RW-1:0]        m;
      logic [NUM_LANES-1:0] neg;
   } post_type;

   typedef struct packed {
      logic [RW-1:0] root;
      logic [RW+1:0] rem;
   } sqs_type;

   typedef struct packed {
      logic [W+1:0]  rem;
      logic [QW-1:0] num;
   } dvs_type;

   // round to nearest, ties up, then saturate; top bit is overflow
   function automatic logic [W:0] round_sat(input logic [AW-1:0] v);
      logic [AW-1:0]   t;
      logic [AW-F-1:0] s;
      logic [W:0]      r;
      t = v + HALF;
      s = t[AW-1:F];
      if ((&s[AW-F-1:W-1]) || !(|s[AW-F-1:W-1])) begin
         r = {1'b0, s[W-1:0]};
      end else begin
         r = {1'b1, s[AW-F-1] ? MINV : MAXV};
      end
      return r;
   endfunction

   function automatic sqs_type sqrt_step(input logic [RW-1:0] root,
                                         input logic [RW+1:0] rem,
                                         input logic [1:0]    dig);
      logic [RW+3:0] t;
      logic [RW+3:0] trial;
      sqs_type       r;
      t     = {rem, dig};
      trial = {2'b00, root, 2'b01};
      if (t >= trial) begin
         r.rem  = (RW+2)'(t - trial);
         r.root = {root[RW-2:0], 1'b1};
      end else begin
         r.rem  = t[RW+1:0];
         r.root = {root[RW-2:0], 1'b0};
      end
      return r;
   endfunction

   function automatic dvs_type div_step(input logic [W+1:0]  rem,
                                        input logic [QW-1:0] num,
                                        input logic [W+1:0]  den);
      logic [W+2:0] t;
      logic [W+2:0] d;
      dvs_type      r;
      t = {rem, num[QW-1]};
      d = {1'b0, den};
      if (t >= d) begin
         r.rem = (W+2)'(t - d);
         r.num = {num[QW-2:0], 1'b1};
      end else begin
         r.rem = t[W+1:0];
         r.num = {num[QW-2:0], 1'b0};
      end
      return r;
   endfunction

   // sum stage
   logic                        s1_vld_ff;
   ctl_type                     s1_ctl_ff;
   logic [NUM_LANES-1:0][W-1:0] s1_a_ff;
   logic [AW-1:0]               s1_sum_ff;
   logic [2:0][AW-1:0]          s1_cr_ff;
   logic [AW-1:0]               s1_sum_in;
   logic [2:0][AW-1:0]          s1_cr_in;

   // round stage
   pay_type       s2_p_ff;
   logic [SP-1:0] s2_s_ff;
   pay_type       s2_p_in;
   logic [SP-1:0] s2_s_in;
   logic [W:0]    rs_dot;
   logic [2:0][W:0] rs_cr;

   // square root stages
   pay_type       sq_p_ff    [RW];
   logic [RW-1:0] sq_root_ff [RW];
   logic [RW+1:0] sq_rem_ff  [RW];
   logic [SP-1:0] sq_s_ff    [RW];
   pay_type       sq_p_src   [RW];
   logic [RW-1:0] sq_root_src[RW];
   logic [RW+1:0] sq_rem_src [RW];
   logic [SP-1:0] sq_s_src   [RW];
   sqs_type       sq_in      [RW];

   // magnitude rounding stage
   post_type                    r_pt_ff;
   logic [NUM_LANES-1:0][W-1:0] r_abs_ff;
   post_type                    r_pt_in;
   logic [NUM_LANES-1:0][W-1:0] r_abs_in;

   // divide setup stage
   post_type                     i_pt_ff;
   logic [NUM_LANES-1:0][W+1:0]  i_rem_ff;
   logic [NUM_LANES-1:0][QW-1:0] i_num_ff;
   logic [NUM_LANES-1:0][W+1:0]  i_rem_in;
   logic [NUM_LANES-1:0][QW-1:0] i_num_in;
   logic [NUM_LANES-1:0][NW-1:0] i_n2;

   // divide stages
   post_type                     dv_pt_ff  [QW];
   logic [NUM_LANES-1:0][W+1:0]  dv_rem_ff [QW];
   logic [NUM_LANES-1:0][QW-1:0] dv_num_ff [QW];
   post_type                     dv_pt_src [QW];
   logic [NUM_LANES-1:0][W+1:0]  dv_rem_src[QW];
   logic [NUM_LANES-1:0][QW-1:0] dv_num_src[QW];
   logic [NUM_LANES-1:0][W+1:0]  dv_rem_in [QW];
   logic [NUM_LANES-1:0][QW-1:0] dv_num_in [QW];
   logic [W+1:0]                 dv_den    [QW];
   dvs_type                      dv_step_r [QW][NUM_LANES];

   // output stage
   post_type                    o_pt;
   logic [NUM_LANES-1:0][W-1:0] lane_res;
   logic [NUM_LANES-1:0]        lane_ovf;
   logic [CW-1:0]               qz [NUM_LANES];
   logic                        o_zero;
   logic                        mag_ovf;
   logic [W-1:0]                mag;

   logic                        out_vld_ff;
   logic [NUM_LANES-1:0][W-1:0] out_res_ff;
   logic [W-1:0]                out_scalar_ff;
   logic                        out_zero_ff;
   logic                        out_ovf_ff;
   logic [NUM_LANES-1:0][W-1:0] out_res_in;
   logic [W-1:0]                out_scalar_in;
   logic                        out_zero_in;
   logic                        out_ovf_in;

   // ---- sum of products and cross differences
   always_comb begin
      s1_sum_in = '0;
      for (int k = 0; k < NUM_LANES; k++) begin
         s1_sum_in = s1_sum_in + {{2{in_prod[k][PW-1]}}, in_prod[k]};
      end
      for (int i = 0; i < 3; i++) begin
         s1_cr_in[i] = {{2{in_prod[2*i][PW-1]}}, in_prod[2*i]}
                     - {{2{in_prod[2*i+1][PW-1]}}, in_prod[2*i+1]};
      end
   end

   // ---- round and saturate dot and cross
   always_comb begin
      rs_dot       = round_sat(s1_sum_ff);
      s2_p_in.vld  = s1_vld_ff;
      s2_p_in.ctl  = s1_ctl_ff;
      s2_p_in.a    = s1_a_ff;
      s2_p_in.dot  = rs_dot[W-1:0];
      for (int i = 0; i < 3; i++) begin
         rs_cr[i]      = round_sat(s1_cr_ff[i]);
         s2_p_in.cr[i] = rs_cr[i][W-1:0];
      end
      s2_p_in.rovf = (s1_ctl_ff.op == OP_DOT) ? rs_dot[W]
                                              : (rs_cr[0][W] | rs_cr[1][W] | rs_cr[2][W]);
      s2_s_in      = {1'b0, s1_sum_ff[2*W:0]};
   end

   // ---- square root, two radicand bits per stage
   always_comb begin
      for (int k = 0; k < RW; k++) begin
         if (k == 0) begin
            sq_p_src[k]    = s2_p_ff;
            sq_root_src[k] = '0;
            sq_rem_src[k]  = '0;
            sq_s_src[k]    = s2_s_ff;
         end else begin
            sq_p_src[k]    = sq_p_ff[k-1];
            sq_root_src[k] = sq_root_ff[k-1];
            sq_rem_src[k]  = sq_rem_ff[k-1];
            sq_s_src[k]    = sq_s_ff[k-1];
         end
         sq_in[k] = sqrt_step(sq_root_src[k], sq_rem_src[k], sq_s_src[k][SP-1:SP-2]);
      end
   end

   // ---- round the root to nearest, take magnitudes of a
   always_comb begin
      r_pt_in.p = sq_p_ff[RW-1];
      r_pt_in.m = sq_root_ff[RW-1]
                + ((sq_rem_ff[RW-1] > {2'b00, sq_root_ff[RW-1]}) ? RW'(1) : RW'(0));
      for (int l = 0; l < NUM_LANES; l++) begin
         r_pt_in.neg[l] = sq_p_ff[RW-1].a[l][W-1];
         r_abs_in[l]    = sq_p_ff[RW-1].a[l][W-1] ? (~sq_p_ff[RW-1].a[l]) + W'(1)
                                                 : sq_p_ff[RW-1].a[l];
      end
   end

   // ---- numerator 2*|a|*2^F + m over denominator 2*m
   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         i_n2[l]     = {1'b0, r_abs_ff[l], {F{1'b0}}, 1'b0}
                     + {{(NW-RW){1'b0}}, r_pt_ff.m};
         i_rem_in[l] = {2'b00, i_n2[l][NW-1:QW]};
         i_num_in[l] = i_n2[l][QW-1:0];
      end
   end

   // ---- restoring divide, one quotient bit per stage and lane
   always_comb begin
      for (int k = 0; k < QW; k++) begin
         if (k == 0) begin
            dv_pt_src[k]  = i_pt_ff;
            dv_rem_src[k] = i_rem_ff;
            dv_num_src[k] = i_num_ff;
         end else begin
            dv_pt_src[k]  = dv_pt_ff[k-1];
            dv_rem_src[k] = dv_rem_ff[k-1];
            dv_num_src[k] = dv_num_ff[k-1];
         end
         dv_den[k] = {dv_pt_src[k].m, 1'b0};
         for (int l = 0; l < NUM_LANES; l++) begin
            dv_step_r[k][l] = div_step(dv_rem_src[k][l], dv_num_src[k][l], dv_den[k]);
            dv_rem_in[k][l] = dv_step_r[k][l].rem;
            dv_num_in[k][l] = dv_step_r[k][l].num;
         end
      end
   end

   // ---- sign, saturation and result select
   always_comb begin
      o_pt    = dv_pt_ff[QW-1];
      o_zero  = (o_pt.m == '0);
      mag_ovf = |o_pt.m[RW-1:W-1];
      mag     = mag_ovf ? MAXV : o_pt.m[W-1:0];
      for (int l = 0; l < NUM_LANES; l++) begin
         qz[l]       = {{W{1'b0}}, dv_num_ff[QW-1][l]};
         lane_ovf[l] = 1'b0;
         if (o_pt.neg[l]) begin
            if (qz[l] > LIM) begin
               lane_ovf[l] = 1'b1;
               lane_res[l] = MINV;
            end else begin
               lane_res[l] = (~qz[l][W-1:0]) + W'(1);
            end
         end else begin
            if (qz[l] >= LIM) begin
               lane_ovf[l] = 1'b1;
               lane_res[l] = MAXV;
            end else begin
               lane_res[l] = qz[l][W-1:0];
            end
         end
      end

      out_res_in    = '0;
      out_scalar_in = '0;
      out_zero_in   = 1'b0;
      out_ovf_in    = 1'b0;
      unique case (o_pt.p.ctl.op)
         OP_DOT: begin
            out_scalar_in = o_pt.p.dot;
            out_ovf_in    = o_pt.p.rovf;
         end
         OP_CROSS: begin
            out_res_in[0] = o_pt.p.cr[0];
            out_res_in[1] = o_pt.p.cr[1];
            out_res_in[2] = o_pt.p.cr[2];
            out_res_in[3] = o_pt.p.ctl.four ? ONE : '0;
            out_ovf_in    = o_pt.p.rovf;
         end
         OP_MAG: begin
            out_scalar_in = mag;
            out_ovf_in    = mag_ovf;
         end
         OP_NORM: begin
            if (o_zero) begin
               out_zero_in = 1'b1;
            end else begin
               out_res_in = lane_res;
               out_ovf_in = |lane_ovf;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      s1_vld_ff <= in_vld;
      s1_ctl_ff <= in_ctl;
      s1_a_ff   <= in_a;
      s1_sum_ff <= s1_sum_in;
      s1_cr_ff  <= s1_cr_in;
      s2_p_ff   <= s2_p_in;
      s2_s_ff   <= s2_s_in;
      for (int k = 0; k < RW; k++) begin
         sq_p_ff[k]    <= sq_p_src[k];
         sq_root_ff[k] <= sq_in[k].root;
         sq_rem_ff[k]  <= sq_in[k].rem;
         sq_s_ff[k]    <= sq_s_src[k] << 2;
      end
      r_pt_ff  <= r_pt_in;
      r_abs_ff <= r_abs_in;
      i_pt_ff  <= r_pt_ff;
      i_rem_ff <= i_rem_in;
      i_num_ff <= i_num_in;
      for (int k = 0; k < QW; k++) begin
         dv_pt_ff[k]  <= dv_pt_src[k];
         dv_rem_ff[k] <= dv_rem_in[k];
         dv_num_ff[k] <= dv_num_in[k];
      end
      out_vld_ff    <= o_pt.p.vld;
      out_res_ff    <= out_res_in;
      out_scalar_ff <= out_scalar_in;
      out_zero_ff   <= out_zero_in;
      out_ovf_ff    <= out_ovf_in;
      if (reset) begin
         s1_vld_ff     <= 1'b0;
         s2_p_ff.vld   <= 1'b0;
         for (int k = 0; k < RW; k++) begin
            sq_p_ff[k].vld <= 1'b0;
         end
         r_pt_ff.p.vld <= 1'b0;
         i_pt_ff.p.vld <= 1'b0;
         for (int k = 0; k < QW; k++) begin
            dv_pt_ff[k].p.vld <= 1'b0;
         end
         out_vld_ff    <= 1'b0;
      end
   end

   assign out_vld    = out_vld_ff;
   assign out_res    = out_res_ff;
   assign out_scalar = out_scalar_ff;
   assign out_zero   = out_zero_ff;
   assign out_ovf    = out_ovf_ff;

endmodule
`default_nettype wire

// ===== rtl/vector3_4_math_unit_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vector3_4_math_unit_top
// dot, cross, magnitude and normalise on 3 or 4 component fixed point vectors
// ----------------------------------------------------------------------------
//  port group   direction  handshake          contents
//  req_*        in         start / busy       op, w mode, vectors a and b
//  rsp_*        out        rsp_valid strobe   result vector, scalar, flags
//
//  one word accepted per clock; busy only rises if the internal queue fills,
//  which the back end prevents by draining it every cycle
//  between accept and strobe each word passes the one-digit-per-stage square
//  root and divider as well as the sum, round and output registers
//  reset is synchronous and clears only valid bits, queue pointers and count
//  the strobe lasts one cycle; the receiver cannot stall the unit
// ----------------------------------------------------------------------------
module vector3_4_math_unit_top import v34m_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_op,
   input  logic                         req_four_components,
   input  logic signed [DATA_WIDTH-1:0] req_a_x,
   input  logic signed [DATA_WIDTH-1:0] req_a_y,
   input  logic signed [DATA_WIDTH-1:0] req_a_z,
   input  logic signed [DATA_WIDTH-1:0] req_a_w,
   input  logic signed [DATA_WIDTH-1:0] req_b_x,
   input  logic signed [DATA_WIDTH-1:0] req_b_y,
   input  logic signed [DATA_WIDTH-1:0] req_b_z,
   input  logic signed [DATA_WIDTH-1:0] req_b_w,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_res_x,
   output logic signed [DATA_WIDTH-1:0] rsp_res_y,
   output logic signed [DATA_WIDTH-1:0] rsp_res_z,
   output logic signed [DATA_WIDTH-1:0] rsp_res_w,
   output logic signed [DATA_WIDTH-1:0] rsp_scalar,
   output logic                         rsp_zero_length,
   output logic                         rsp_overflow
);

   localparam int W  = DATA_WIDTH;
   localparam int QB = CTL_BITS + NUM_LANES * W + NUM_PRODS * 2 * W;

   ctl_type                       req_ctl;
   logic                          take;
   logic                          q_full;
   logic                          push;
   ctl_type                       f_ctl;
   logic [NUM_LANES-1:0][W-1:0]   f_a;
   logic [NUM_PRODS-1:0][2*W-1:0] f_prod;
   logic [QB-1:0]                 q_wdata;
   logic [QB-1:0]                 q_rdata;
   logic                          q_vld;
   ctl_type                       b_ctl;
   logic [NUM_LANES-1:0][W-1:0]   b_a;
   logic [NUM_PRODS-1:0][2*W-1:0] b_prod;
   logic [NUM_LANES-1:0][W-1:0]   b_res;

   // command decode
   assign req_ctl.op   = op_type'(req_op);
   assign req_ctl.four = req_four_components;
   assign busy         = q_full;
   assign take         = start & ~busy;

   // front: input register, operand select, multipliers
   v34m_front #(.W(W)) u_front (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .stall    (q_full),
      .ctl_in   (req_ctl),
      .a_in     ({req_a_w, req_a_z, req_a_y, req_a_x}),
      .b_in     ({req_b_w, req_b_z, req_b_y, req_b_x}),
      .push     (push),
      .ctl_out  (f_ctl),
      .a_out    (f_a),
      .prod_out (f_prod)
   );

   // queue between the two halves; back end always pops
   assign q_wdata = {f_ctl, f_a, f_prod};

   v34m_queue #(.WIDTH(QB), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .wdata  (q_wdata),
      .pop    (1'b1),
      .full   (q_full),
      .rd_vld (q_vld),
      .rdata  (q_rdata)
   );

   assign {b_ctl, b_a, b_prod} = q_rdata;

   // back: sums, rounding, root, divide, result word
   v34m_back #(.W(W), .F(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_vld     (q_vld),
      .in_ctl     (b_ctl),
      .in_a       (b_a),
      .in_prod    (b_prod),
      .out_vld    (rsp_valid),
      .out_res    (b_res),
      .out_scalar (rsp_scalar),
      .out_zero   (rsp_zero_length),
      .out_ovf    (rsp_overflow)
   );

   assign rsp_res_x = b_res[0];
   assign rsp_res_y = b_res[1];
   assign rsp_res_z = b_res[2];
   assign rsp_res_w = b_res[3];

   // the queue never backs up because the back end drains it every cycle
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("queue backed up");

   // a zero vector in normalise gives an all zero result and no overflow
   a_zero_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_length |->
         !rsp_overflow && rsp_scalar == '0 && rsp_res_x == '0 &&
         rsp_res_y == '0 && rsp_res_z == '0 && rsp_res_w == '0)
      else $error("zero length result not clean");

   // nothing is pushed into the queue without a word having been accepted
   a_push_needs_take: assert property (@(posedge clock) disable iff (reset)
      push |-> $past(take, 2))
      else $error("queue push without accepted word");

endmodule
`default_nettype wire
